>>> rtl/plc_pkg.sv
// ----------------------------------------------------------------------------
// plc_pkg
// Shared types, codes and reset constants for the prescaled limit counter.
// ----------------------------------------------------------------------------
package plc_pkg;

   localparam int VALUE_WIDTH_DEFAULT = 32;

   // csr map
   localparam logic [2:0] CSR_PERIOD       = 3'd0;
   localparam logic [2:0] CSR_INITIAL_STEP = 3'd1;
   localparam logic [2:0] CSR_LOW_LIMIT    = 3'd2;
   localparam logic [2:0] CSR_HIGH_LIMIT   = 3'd3;
   localparam logic [2:0] CSR_LIMIT_MODE   = 3'd4;

   localparam logic        [15:0] PERIOD_RESET = 16'd10;
   localparam logic signed [15:0] STEP_RESET   = 16'sd1;
   localparam logic signed [31:0] LOW_RESET    = 32'sd0;
   localparam logic signed [31:0] HIGH_RESET   = 32'sd100;

   localparam logic signed [15:0] STEP_MIN = 16'sh8000;
   localparam logic signed [15:0] STEP_MAX = 16'sh7fff;

   typedef enum logic {
      CMD_TICK          = 1'b0,
      CMD_WRITE_CONTROL = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      CTL_STOPPED      = 2'd0,
      CTL_RUN          = 2'd1,
      CTL_REWIND       = 2'd2,
      CTL_FAST_FORWARD = 2'd3
   } ctl_type;

   typedef enum logic [2:0] {
      MODE_STOP    = 3'd0,
      MODE_LOOP    = 3'd1,
      MODE_SHUTTLE = 3'd2,
      MODE_DOWN_UP = 3'd3,
      MODE_UP_DOWN = 3'd4
   } mode_type;

   localparam mode_type MODE_RESET = MODE_STOP;

   typedef struct packed {
      logic signed [31:0] count_value;
      ctl_type            control_now;
      logic               acted;
   } rsp_type;

endpackage

>>> rtl/plc_step.sv
// ----------------------------------------------------------------------------
// plc_step
// Next-state logic for one item: prescaler, control and limit handling.
// ----------------------------------------------------------------------------
module plc_step #(
   parameter int VALUE_WIDTH = plc_pkg::VALUE_WIDTH_DEFAULT
) (
   input  plc_pkg::cmd_type                cmd,
   input  plc_pkg::ctl_type                control_value,
   input  logic                     [15:0] period,
   input  logic signed              [31:0] low_limit,
   input  logic signed              [31:0] high_limit,
   input  plc_pkg::mode_type               limit_mode,
   input  logic                     [15:0] tick_count,
   input  logic signed   [VALUE_WIDTH-1:0] count_value,
   input  logic signed              [15:0] running_step,
   input  plc_pkg::ctl_type                control_state,
   output logic                     [15:0] tick_count_next,
   output logic signed   [VALUE_WIDTH-1:0] count_next,
   output logic signed              [15:0] step_next,
   output plc_pkg::ctl_type                control_next,
   output plc_pkg::rsp_type                result
);
   import plc_pkg::*;

   // arithmetic width: wide enough that saturation only bites at 64 bits
   localparam int AW = (VALUE_WIDTH > 61) ? 64 :
                       ((VALUE_WIDTH > 32) ? VALUE_WIDTH + 3 : 35);
   localparam logic signed [AW-1:0] X_MAX = {1'b0, {(AW-1){1'b1}}};
   localparam logic signed [AW-1:0] X_MIN = {1'b1, {(AW-1){1'b0}}};
   localparam logic signed [AW-1:0] X_ONE = AW'(1);

   function automatic logic signed [AW-1:0] sat_add(input logic signed [AW-1:0] a,
                                                    input logic signed [AW-1:0] b);
      logic [AW:0] s;
      s = {a[AW-1], a} + {b[AW-1], b};
      if (s[AW] != s[AW-1]) sat_add = s[AW] ? X_MIN : X_MAX;
      else sat_add = s[AW-1:0];
   endfunction

   function automatic logic signed [AW-1:0] sat_sub(input logic signed [AW-1:0] a,
                                                    input logic signed [AW-1:0] b);
      logic [AW:0] s;
      s = {a[AW-1], a} - {b[AW-1], b};
      if (s[AW] != s[AW-1]) sat_sub = s[AW] ? X_MIN : X_MAX;
      else sat_sub = s[AW-1:0];
   endfunction

   function automatic logic signed [15:0] neg_step(input logic signed [15:0] s);
      neg_step = (s == STEP_MIN) ? STEP_MAX : -s;
   endfunction

   logic        [15:0] tick_inc;
   logic signed [AW-1:0] lo_x;
   logic signed [AW-1:0] hi_x;
   logic signed [AW-1:0] v_x;
   logic signed [AW-1:0] lim_x;
   logic signed [15:0]   lim_step;
   logic                 fits;

   assign tick_inc = tick_count + 16'd1;
   assign lo_x     = AW'(low_limit);
   assign hi_x     = AW'(high_limit);
   assign v_x      = sat_add(AW'(count_value), AW'(running_step));

   // limit handling for a run action
   always_comb begin
      lim_x    = v_x;
      lim_step = running_step;
      if (lo_x == hi_x) begin
         lim_x = hi_x;
      end else begin
         case (limit_mode)
            MODE_STOP: begin
               if (lim_x > hi_x) lim_x = hi_x;
               if (lim_x < lo_x) lim_x = lo_x;
            end
            MODE_LOOP: begin
               if (v_x > hi_x) begin
                  lim_x = sat_sub(sat_add(lo_x, sat_sub(v_x, hi_x)), X_ONE);
               end else if (v_x < lo_x) begin
                  lim_x = sat_add(sat_sub(hi_x, sat_sub(lo_x, v_x)), X_ONE);
               end
            end
            MODE_SHUTTLE: begin
               if (v_x > hi_x) begin
                  lim_x    = sat_sub(hi_x, sat_sub(v_x, hi_x));
                  lim_step = neg_step(running_step);
               end else if (v_x < lo_x) begin
                  lim_x    = sat_add(lo_x, sat_sub(lo_x, v_x));
                  lim_step = neg_step(running_step);
               end
            end
            MODE_DOWN_UP: begin
               if (v_x < lo_x) begin
                  lim_x    = sat_add(lo_x, sat_sub(lo_x, v_x));
                  lim_step = neg_step(running_step);
               end else if (v_x > hi_x) begin
                  lim_x = hi_x;
               end
            end
            MODE_UP_DOWN: begin
               if (v_x > hi_x) begin
                  lim_x    = sat_sub(hi_x, sat_sub(v_x, hi_x));
                  lim_step = neg_step(running_step);
               end else if (v_x < lo_x) begin
                  lim_x = lo_x;
               end
            end
            default: begin
               // unused modes: plain add
            end
         endcase
      end
   end

   logic signed [AW-1:0] act_x;
   logic                 act;

   always_comb begin
      tick_count_next = tick_count;
      step_next       = running_step;
      control_next    = control_state;
      act             = 1'b0;
      act_x           = lim_x;
      if (cmd == CMD_WRITE_CONTROL) begin
         control_next = control_value;
      end else if (control_state != CTL_STOPPED) begin
         tick_count_next = tick_inc;
         if (tick_inc >= period) begin
            tick_count_next = '0;
            act             = 1'b1;
            case (control_state)
               CTL_RUN: begin
                  act_x     = lim_x;
                  step_next = lim_step;
               end
               CTL_REWIND: begin
                  act_x        = lo_x;
                  control_next = CTL_RUN;
               end
               default: begin
                  act_x        = hi_x;
                  control_next = CTL_RUN;
               end
            endcase
         end
      end
   end

   // saturate to the stored width
   assign fits = (&act_x[AW-1:VALUE_WIDTH-1]) | ~(|act_x[AW-1:VALUE_WIDTH-1]);

   always_comb begin
      count_next = count_value;
      if (act) begin
         if (fits) count_next = act_x[VALUE_WIDTH-1:0];
         else count_next = act_x[AW-1] ? {1'b1, {(VALUE_WIDTH-1){1'b0}}}
                                       : {1'b0, {(VALUE_WIDTH-1){1'b1}}};
      end
   end

   logic signed [31:0] count_out;

   generate
      if (VALUE_WIDTH > 32) begin : g_clamp
         logic out_fits;
         assign out_fits = (&count_next[VALUE_WIDTH-1:31]) |
                           ~(|count_next[VALUE_WIDTH-1:31]);
         assign count_out = out_fits ? count_next[31:0]
                          : (count_next[VALUE_WIDTH-1] ? 32'sh8000_0000 : 32'sh7fff_ffff);
      end else begin : g_extend
         assign count_out = 32'(count_next);
      end
   endgenerate

   assign result.count_value = count_out;
   assign result.control_now = control_next;
   assign result.acted       = act;

endmodule

>>> rtl/plc_rsp_buf.sv
// ----------------------------------------------------------------------------
// plc_rsp_buf
// Two-entry result buffer: output register plus skid register.
// ----------------------------------------------------------------------------
module plc_rsp_buf (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  plc_pkg::rsp_type push_data,
   input  logic             out_stall,
   output logic             out_valid,
   output plc_pkg::rsp_type out_data,
   output logic             full
);
   import plc_pkg::*;

   rsp_type main_ff;
   rsp_type main_in;
   logic    main_valid_ff;
   logic    main_valid_in;
   rsp_type skid_ff;
   logic    skid_valid_ff;
   logic    skid_valid_in;
   logic    skid_load;
   logic    take;

   assign take = main_valid_ff & ~out_stall;

   always_comb begin
      main_in       = main_ff;
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      skid_load     = 1'b0;
      if (take | ~main_valid_ff) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = push_data;
            main_valid_in = push;
         end
      end else if (push) begin
         // output held: park the transfer in the skid slot
         skid_load     = 1'b1;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      if (skid_load) skid_ff <= push_data;
   end

   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;
   assign full      = skid_valid_ff;

endmodule

>>> rtl/prescaled_limit_counter_unit.sv
// ----------------------------------------------------------------------------
// prescaled_limit_counter_unit
// Prescaled signed counter with selectable limit behavior.
// ----------------------------------------------------------------------------
//   channel | direction | handshake        | payload
//   req     | in        | req_valid/stall  | command, control_value
//   rsp     | out       | rsp_valid/stall  | count_value, control_now, acted
//   csr     | in        | csr_write_en     | csr_index, csr_data
//
// One item per cycle while req_stall is low; a result is held in the output or the
// skid register. The counter update (add, limit compare, select) is combinational.
// Reset restores config, valid flags and counter state; no clearing pass.
// rsp_stall is absorbed by an output and a skid register; req_stall rises
// only once both hold results.
// ----------------------------------------------------------------------------
module prescaled_limit_counter_unit #(
   parameter int VALUE_WIDTH = plc_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_command,
   input  logic        [1:0]  req_control_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_count_value,
   output logic        [1:0]  rsp_control_now,
   output logic               rsp_acted,
   input  logic               csr_write_en,
   input  logic        [2:0]  csr_index,
   input  logic        [31:0] csr_data
);
   import plc_pkg::*;

   // configuration
   logic        [15:0] period_ff;
   logic signed [15:0] initial_step_ff;
   logic signed [31:0] low_limit_ff;
   logic signed [31:0] high_limit_ff;
   mode_type           limit_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff       <= PERIOD_RESET;
         initial_step_ff <= STEP_RESET;
         low_limit_ff    <= LOW_RESET;
         high_limit_ff   <= HIGH_RESET;
         limit_mode_ff   <= MODE_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_PERIOD:       period_ff       <= csr_data[15:0];
            CSR_INITIAL_STEP: initial_step_ff <= csr_data[15:0];
            CSR_LOW_LIMIT:    low_limit_ff    <= csr_data;
            CSR_HIGH_LIMIT:   high_limit_ff   <= csr_data;
            CSR_LIMIT_MODE:   limit_mode_ff   <= mode_type'(csr_data[2:0]);
            default: begin
            end
         endcase
      end
   end

   // counter state
   logic        [15:0]            tick_ff;
   logic        [15:0]            tick_in;
   logic signed [VALUE_WIDTH-1:0] count_ff;
   logic signed [VALUE_WIDTH-1:0] count_in;
   logic signed [15:0]            step_ff;
   logic signed [15:0]            step_in;
   ctl_type                       control_ff;
   ctl_type                       control_in;
   rsp_type                       result;
   rsp_type                       rsp_data;
   logic                          req_xfer;

   assign req_xfer = req_valid & ~req_stall;

   plc_step #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_step (
      .cmd             (cmd_type'(req_command)),
      .control_value   (ctl_type'(req_control_value)),
      .period          (period_ff),
      .low_limit       (low_limit_ff),
      .high_limit      (high_limit_ff),
      .limit_mode      (limit_mode_ff),
      .tick_count      (tick_ff),
      .count_value     (count_ff),
      .running_step    (step_ff),
      .control_state   (control_ff),
      .tick_count_next (tick_in),
      .count_next      (count_in),
      .step_next       (step_in),
      .control_next    (control_in),
      .result          (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff    <= '0;
         count_ff   <= '0;
         step_ff    <= STEP_RESET;
         control_ff <= CTL_RUN;
      end else if (req_xfer) begin
         tick_ff    <= tick_in;
         count_ff   <= count_in;
         step_ff    <= step_in;
         control_ff <= control_in;
      end
   end

   plc_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (req_xfer),
      .push_data (result),
      .out_stall (rsp_stall),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .full      (req_stall)
   );

   assign rsp_count_value = rsp_data.count_value;
   assign rsp_control_now = rsp_data.control_now;
   assign rsp_acted       = rsp_data.acted;

   // skid slot never fills ahead of the output register
   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("skid holds a result while output register is empty");

   // after every accepted transfer, rsp_valid is high next cycle
   a_xfer_result: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> rsp_valid)
      else $error("accepted transfer produced no result");

   // a tick while stopped leaves the counter alone
   a_stopped_hold: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_command == CMD_TICK && control_ff == CTL_STOPPED)
      |=> ($stable(count_ff) && $stable(tick_ff)))
      else $error("stopped counter changed on a tick");

   // an action clears the prescaler
   a_act_clears: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && result.acted) |=> (tick_ff == 16'd0))
      else $error("prescaler not cleared after action");

   // running step holds without a transfer; the initial step register does not feed it
   a_step_const: assert property (@(posedge clock) disable iff (reset)
      (!req_xfer && $past(!reset) && $past(!req_xfer)) |->
         $stable(step_ff) || $past(initial_step_ff) != initial_step_ff)
      else $error("running step moved without a transfer");

endmodule
